// ===== rtl/tlssni_pkg.sv =====
// ----------------------------------------------------------------------------
// TLS SNI extractor package
// Parse phases, status codes, protocol constants and the result item type.
// ----------------------------------------------------------------------------
package tlssni_pkg;

  localparam logic [7:0]  HANDSHAKE_CONTENT = 8'h16;
  localparam logic [7:0]  CLIENT_HELLO_TYPE = 8'h01;
  localparam logic [7:0]  SSL2_LENGTH_BIT   = 8'h80;
  localparam logic [15:0] FIXED_SKIP_LEN    = 16'd38;
  localparam logic [16:0] RECORD_HEADER_LEN = 17'd5;
  localparam logic [16:0] POS_MAX           = 17'h1FFFF;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    ST_FOUND      = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_NOSNI      = 2'd2,
    ST_MALFORMED  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    PH_HDR        = 5'd0,
    PH_HS_TYPE    = 5'd1,
    PH_FIXED_SKIP = 5'd2,
    PH_SID_LEN    = 5'd3,
    PH_SID_SKIP   = 5'd4,
    PH_CS_HI      = 5'd5,
    PH_CS_LO      = 5'd6,
    PH_CS_SKIP    = 5'd7,
    PH_CM_LEN     = 5'd8,
    PH_CM_SKIP    = 5'd9,
    PH_EXTS_HI    = 5'd10,
    PH_EXTS_LO    = 5'd11,
    PH_EXT_T0     = 5'd12,
    PH_EXT_T1     = 5'd13,
    PH_EXT_L0     = 5'd14,
    PH_EXT_L1     = 5'd15,
    PH_EXT_SKIP   = 5'd16,
    PH_SNL_SKIP   = 5'd17,
    PH_NAME_TYPE  = 5'd18,
    PH_NAME_L0    = 5'd19,
    PH_NAME_L1    = 5'd20,
    PH_NAME_SKIP  = 5'd21,
    PH_NAME_COPY  = 5'd22,
    PH_DONE       = 5'd23
  } phase_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  host_byte;
    status_t     status;
    logic [15:0] name_length;
    logic        last;
  } out_item_t;

endpackage

// ===== rtl/tls_sni_hostname_extractor_top.sv =====
// Latency: a request is parsed in the cycle it is accepted; its results are
// offered on the master side from the next cycle on, through a 4-entry queue.
// Throughput: one byte per cycle; a byte yields at most two results (a host
// name byte and the final status), and the queue must hold two free entries.
// Reset: rst is synchronous, active high, clears the parser and the queue.
// The parser also clears itself after each byte marked as the packet end.
// ----------------------------------------------------------------------------
// TLS SNI host name extractor
// Parses a TLS ClientHello byte by byte and streams out the first host name.
// ----------------------------------------------------------------------------
module tls_sni_hostname_extractor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_packet
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] host_byte, [9:8] status, [25:10] name_length
  output logic        m_tuser,   // item_kind
  output logic        m_tlast    // last
);
  import tlssni_pkg::*;

  // Parser state
  phase_t      phase, phase_next;
  logic [16:0] byte_position;
  logic [16:0] record_end, record_end_next;
  logic [15:0] field_remaining, field_remaining_next;
  logic [16:0] ext_list_end, ext_list_end_next;
  logic [16:0] ext_end, ext_end_next;
  logic [7:0]  version_major, version_major_next;
  logic [7:0]  version_minor, version_minor_next;
  logic [7:0]  first_byte, first_byte_next;
  logic [7:0]  length_high, length_high_next;
  status_t     outcome_code, outcome_code_next;
  logic [15:0] found_length, found_length_next;
  logic        type_zero, type_zero_next;

  // Result queue
  out_item_t            fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_AW:0]     count;

  logic        accept, pop;
  logic [7:0]  b;
  logic [15:0] ln;
  logic [17:0] q18, t18, sb18;
  logic        in_body, name_emit;
  status_t     eop_status;
  out_item_t   res0, res1;
  logic [1:0]  n_push;

  assign accept = s_tvalid && s_tready;
  assign pop    = m_tvalid && m_tready;
  assign b      = s_tdata;
  assign ln     = {length_high, b};
  assign q18    = 18'(byte_position);
  assign t18    = q18 + 18'd1 + 18'(ln);
  assign sb18   = q18 + 18'd1 + 18'(b);
  assign in_body = (phase != PH_HDR) && (phase != PH_DONE) && (byte_position < record_end);

  // Next-state logic of the parser
  always_comb begin
    phase_next           = phase;
    record_end_next      = record_end;
    field_remaining_next = field_remaining;
    ext_list_end_next    = ext_list_end;
    ext_end_next         = ext_end;
    version_major_next   = version_major;
    version_minor_next   = version_minor;
    first_byte_next      = first_byte;
    length_high_next     = length_high;
    outcome_code_next    = outcome_code;
    found_length_next    = found_length;
    type_zero_next       = type_zero;

    if (phase == PH_HDR) begin
      case (byte_position)
        17'd0: first_byte_next = b;
        17'd1: version_major_next = b;
        17'd2: version_minor_next = b;
        17'd3: length_high_next = b;
        default: begin
          record_end_next = 17'(ln) + RECORD_HEADER_LEN;
          if (((first_byte & SSL2_LENGTH_BIT) != 8'd0) && (version_minor == 8'd1)) begin
            record_end_next   = RECORD_HEADER_LEN;
            outcome_code_next = ST_NOSNI;
            phase_next        = PH_DONE;
          end else if (first_byte != HANDSHAKE_CONTENT) begin
            record_end_next   = RECORD_HEADER_LEN;
            outcome_code_next = ST_MALFORMED;
            phase_next        = PH_DONE;
          end else if (version_major < 8'd3) begin
            record_end_next   = RECORD_HEADER_LEN;
            outcome_code_next = ST_NOSNI;
            phase_next        = PH_DONE;
          end else if (ln == 16'd0) begin
            // A record too short to hold even the handshake type.
            outcome_code_next = ST_MALFORMED;
            phase_next        = PH_DONE;
          end else begin
            phase_next = PH_HS_TYPE;
          end
        end
      endcase
    end else if (in_body) begin
      case (phase)
        PH_HS_TYPE: begin
          if (b != CLIENT_HELLO_TYPE ||
              (RECORD_HEADER_LEN + 17'(FIXED_SKIP_LEN) + 17'd1) > record_end) begin
            outcome_code_next = ST_MALFORMED;
            phase_next        = PH_DONE;
          end else begin
            field_remaining_next = FIXED_SKIP_LEN - 16'd1;
            phase_next           = PH_FIXED_SKIP;
          end
        end
        PH_SID_LEN: begin
          if (sb18 + 18'd2 > 18'(record_end)) begin
            outcome_code_next = ST_MALFORMED;
            phase_next        = PH_DONE;
          end else if (b == 8'd0) begin
            phase_next = PH_CS_HI;
          end else begin
            field_remaining_next = 16'(b);
            phase_next           = PH_SID_SKIP;
          end
        end
        PH_CS_HI: begin
          length_high_next = b;
          phase_next       = PH_CS_LO;
        end
        PH_EXTS_HI: begin
          length_high_next = b;
          phase_next       = PH_EXTS_LO;
        end
        PH_EXT_L0: begin
          length_high_next = b;
          phase_next       = PH_EXT_L1;
        end
        PH_NAME_L0: begin
          length_high_next = b;
          phase_next       = PH_NAME_L1;
        end
        PH_CS_LO: begin
          if (t18 + 18'd1 > 18'(record_end)) begin
            outcome_code_next = ST_MALFORMED;
            phase_next        = PH_DONE;
          end else if (ln == 16'd0) begin
            phase_next = PH_CM_LEN;
          end else begin
            field_remaining_next = ln;
            phase_next           = PH_CS_SKIP;
          end
        end
        PH_CM_LEN: begin
          if (sb18 == 18'(record_end) && version_major == 8'd3 && version_minor == 8'd0) begin
            // SSL 3.0 hello without an extension block.
            outcome_code_next = ST_NOSNI;
            phase_next        = PH_DONE;
          end else if (sb18 + 18'd2 > 18'(record_end)) begin
            outcome_code_next = ST_MALFORMED;
            phase_next        = PH_DONE;
          end else if (b == 8'd0) begin
            phase_next = PH_EXTS_HI;
          end else begin
            field_remaining_next = 16'(b);
            phase_next           = PH_CM_SKIP;
          end
        end
        PH_EXTS_LO: begin
          if (t18 > 18'(record_end)) begin
            outcome_code_next = ST_MALFORMED;
            phase_next        = PH_DONE;
          end else begin
            ext_list_end_next = t18[16:0];
            if (q18 + 18'd5 <= t18) begin
              phase_next = PH_EXT_T0;
            end else begin
              outcome_code_next = (q18 + 18'd1 == t18) ? ST_NOSNI : ST_MALFORMED;
              phase_next        = PH_DONE;
            end
          end
        end
        PH_EXT_T0: begin
          type_zero_next = (b == 8'd0);
          phase_next     = PH_EXT_T1;
        end
        PH_EXT_T1: begin
          type_zero_next = type_zero && (b == 8'd0);
          phase_next     = PH_EXT_L0;
        end
        PH_EXT_L1: begin
          if (type_zero) begin
            // Server name extension: skip the list length, then the entries.
            if (t18 > 18'(ext_list_end)) begin
              outcome_code_next = ST_MALFORMED;
              phase_next        = PH_DONE;
            end else begin
              ext_end_next = t18[16:0];
              if (q18 + 18'd6 < t18) begin
                field_remaining_next = 16'd2;
                phase_next           = PH_SNL_SKIP;
              end else begin
                outcome_code_next = (q18 + 18'd3 == t18) ? ST_NOSNI : ST_MALFORMED;
                phase_next        = PH_DONE;
              end
            end
          end else if (19'(t18) + 19'd4 <= 19'(ext_list_end)) begin
            if (ln == 16'd0) begin
              phase_next = PH_EXT_T0;
            end else begin
              field_remaining_next = ln;
              phase_next           = PH_EXT_SKIP;
            end
          end else begin
            outcome_code_next = (t18 == 18'(ext_list_end)) ? ST_NOSNI : ST_MALFORMED;
            phase_next        = PH_DONE;
          end
        end
        PH_NAME_TYPE: begin
          type_zero_next = (b == 8'd0);
          phase_next     = PH_NAME_L0;
        end
        PH_NAME_L1: begin
          if (t18 > 18'(ext_end)) begin
            outcome_code_next = ST_MALFORMED;
            phase_next        = PH_DONE;
          end else if (type_zero) begin
            found_length_next = ln;
            outcome_code_next = ST_FOUND;
            if (ln == 16'd0) begin
              phase_next = PH_DONE;
            end else begin
              field_remaining_next = ln;
              phase_next           = PH_NAME_COPY;
            end
          end else if (19'(t18) + 19'd3 < 19'(ext_end)) begin
            if (ln == 16'd0) begin
              phase_next = PH_NAME_TYPE;
            end else begin
              field_remaining_next = ln;
              phase_next           = PH_NAME_SKIP;
            end
          end else begin
            outcome_code_next = (t18 == 18'(ext_end)) ? ST_NOSNI : ST_MALFORMED;
            phase_next        = PH_DONE;
          end
        end
        PH_NAME_COPY: begin
          if (field_remaining <= 16'd1) begin
            phase_next = PH_DONE;
          end else begin
            field_remaining_next = field_remaining - 16'd1;
          end
        end
        default: begin
          // Skip phases count down and then move on to the field that follows.
          if (field_remaining <= 16'd1) begin
            case (phase)
              PH_FIXED_SKIP: phase_next = PH_SID_LEN;
              PH_SID_SKIP:   phase_next = PH_CS_HI;
              PH_CS_SKIP:    phase_next = PH_CM_LEN;
              PH_CM_SKIP:    phase_next = PH_EXTS_HI;
              PH_EXT_SKIP:   phase_next = PH_EXT_T0;
              default:       phase_next = PH_NAME_TYPE;
            endcase
          end else begin
            field_remaining_next = field_remaining - 16'd1;
          end
        end
      endcase
    end
  end

  // Result generation
  always_comb begin
    name_emit = in_body && (phase == PH_NAME_COPY);

    if ((q18 + 18'd1 < 18'(RECORD_HEADER_LEN)) || (q18 + 18'd1 < 18'(record_end_next))) begin
      eop_status = ST_INCOMPLETE;
    end else begin
      eop_status = outcome_code_next;
    end

    res1.item_kind   = 1'b1;
    res1.host_byte   = 8'd0;
    res1.status      = eop_status;
    res1.name_length = (eop_status == ST_FOUND) ? found_length_next : 16'd0;
    res1.last        = 1'b1;

    if (name_emit) begin
      res0.item_kind   = 1'b0;
      res0.host_byte   = b;
      res0.status      = ST_FOUND;
      res0.name_length = 16'd0;
      res0.last        = 1'b0;
      n_push           = {1'b0, name_emit} + {1'b0, s_tlast};
    end else begin
      res0   = res1;
      n_push = {1'b0, s_tlast};
    end
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      phase           <= PH_HDR;
      byte_position   <= 17'd0;
      record_end      <= 17'd0;
      field_remaining <= 16'd0;
      ext_list_end    <= 17'd0;
      ext_end         <= 17'd0;
      version_major   <= 8'd0;
      version_minor   <= 8'd0;
      first_byte      <= 8'd0;
      length_high     <= 8'd0;
      outcome_code    <= ST_INCOMPLETE;
      found_length    <= 16'd0;
      type_zero       <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      if (byte_position < POS_MAX) begin
        byte_position <= byte_position + 17'd1;
      end
      record_end      <= record_end_next;
      field_remaining <= field_remaining_next;
      ext_list_end    <= ext_list_end_next;
      ext_end         <= ext_end_next;
      version_major   <= version_major_next;
      version_minor   <= version_minor_next;
      first_byte      <= first_byte_next;
      length_high     <= length_high_next;
      outcome_code    <= outcome_code_next;
      found_length    <= found_length_next;
      type_zero       <= type_zero_next;
    end
  end

  // Result queue: up to two writes and one read per cycle.
  assign s_tready = (count <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign m_tvalid = (count != '0);

  always_ff @(posedge clk) begin
    if (accept && (n_push != 2'd0)) begin
      fifo[wr_ptr] <= res0;
      if (n_push == 2'd2) begin
        fifo[wr_ptr + FIFO_AW'(1)] <= res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + FIFO_AW'(n_push);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + (FIFO_AW+1)'(accept ? n_push : 2'd0) - (FIFO_AW+1)'(pop);
    end
  end

  assign m_tdata = {6'd0, fifo[rd_ptr].name_length, fifo[rd_ptr].status,
                    fifo[rd_ptr].host_byte};
  assign m_tuser = fifo[rd_ptr].item_kind;
  assign m_tlast = fifo[rd_ptr].last;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TLS SNI host name extractor testbench
// Feeds TLS ClientHello records and broken or unrelated payloads byte by byte,
// predicts the streamed host name and the closing status of each packet, and
// checks every result leaving the block under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
  import tlssni_pkg::*;

  typedef logic [7:0] byte_q_t [$];

  typedef struct {
    logic [7:0]  content;
    logic [7:0]  ver_major;
    logic [7:0]  ver_minor;
    logic [7:0]  hs_type;
    int          sid_len;
    int          cs_len;
    int          cm_len;
    bit          has_exts;
    int          pre_exts;
    int          post_exts;
    int          pad_len;
    bit          has_sni;
    bit          other_first;
    bit          host_entry;
    bit          trailing_entry;
    int          name_len;
    bit          name_binary;
    logic [15:0] snl_field;
  } hello_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int send_idle;
  int recv_idle;
  int hold_request;
  int hold_left;
  int mismatches;

  // Parser model state.
  phase_t      ph;
  logic [16:0] pos;
  logic [16:0] rec_end;
  logic [16:0] ext_list_end;
  logic [16:0] ext_end;
  logic [15:0] field_left;
  logic [7:0]  ver_major;
  logic [7:0]  ver_minor;
  logic [7:0]  lead_byte;
  logic [7:0]  len_hi;
  status_t     outcome;
  logic [15:0] found_len;
  bit          type_zero;

  out_item_t   sni_due [$];

  tls_sni_hostname_extractor_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("[tls_sni_hostname_extractor_top] ERROR");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < 40) begin
      $display("mismatch at %0t: %s, got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // ---------------------------------------------------------------- parser model

  function automatic void clear_parser();
    ph           = PH_HDR;
    pos          = '0;
    rec_end      = '0;
    ext_list_end = '0;
    ext_end      = '0;
    field_left   = '0;
    ver_major    = '0;
    ver_minor    = '0;
    lead_byte    = '0;
    len_hi       = '0;
    outcome      = ST_INCOMPLETE;
    found_len    = '0;
    type_zero    = 1'b0;
  endfunction

  function automatic void settle(status_t code);
    outcome = code;
    ph      = PH_DONE;
  endfunction

  function automatic void skip_then(phase_t skip_ph, phase_t next_ph, int unsigned n);
    if (n == 0) begin
      ph = next_ph;
    end else begin
      field_left = 16'(n);
      ph         = skip_ph;
    end
  endfunction

  function automatic phase_t after_skip(phase_t p);
    case (p)
      PH_FIXED_SKIP: return PH_SID_LEN;
      PH_SID_SKIP:   return PH_CS_HI;
      PH_CS_SKIP:    return PH_CM_LEN;
      PH_CM_SKIP:    return PH_EXTS_HI;
      PH_EXT_SKIP:   return PH_EXT_T0;
      default:       return PH_NAME_TYPE;
    endcase
  endfunction

  // An extension header needs four bytes; a list that ends exactly means no name.
  function automatic bit ext_fits(int unsigned p);
    if (p + 4 <= ext_list_end) return 1'b1;
    settle(p == ext_list_end ? ST_NOSNI : ST_MALFORMED);
    return 1'b0;
  endfunction

  function automatic bit name_fits(int unsigned p);
    if (p + 3 < ext_end) return 1'b1;
    settle(p == ext_end ? ST_NOSNI : ST_MALFORMED);
    return 1'b0;
  endfunction

  function automatic void parse_hello_byte(logic [7:0] b, logic eop);
    int unsigned q;
    int unsigned ln;
    int unsigned t;
    int unsigned sb;
    out_item_t   item;
    q  = pos;
    ln = {len_hi, b};
    t  = q + 1 + ln;
    sb = q + 1 + b;
    if (ph == PH_HDR) begin
      if (q == 0) lead_byte = b;
      else if (q == 1) ver_major = b;
      else if (q == 2) ver_minor = b;
      else if (q == 3) len_hi = b;
      else begin
        rec_end = 17'(ln + RECORD_HEADER_LEN);
        if ((lead_byte & SSL2_LENGTH_BIT) != 0 && ver_minor == 8'd1) begin
          rec_end = RECORD_HEADER_LEN;
          settle(ST_NOSNI);
        end else if (lead_byte != HANDSHAKE_CONTENT) begin
          rec_end = RECORD_HEADER_LEN;
          settle(ST_MALFORMED);
        end else if (ver_major < 8'd3) begin
          rec_end = RECORD_HEADER_LEN;
          settle(ST_NOSNI);
        end else if (RECORD_HEADER_LEN + 1 > rec_end) begin
          settle(ST_MALFORMED);
        end else begin
          ph = PH_HS_TYPE;
        end
      end
    end else if (ph != PH_DONE && q < rec_end) begin
      case (ph)
        PH_HS_TYPE: begin
          if (b != CLIENT_HELLO_TYPE || RECORD_HEADER_LEN + FIXED_SKIP_LEN + 1 > rec_end)
            settle(ST_MALFORMED);
          else
            skip_then(PH_FIXED_SKIP, PH_SID_LEN, FIXED_SKIP_LEN - 1);
        end
        PH_SID_LEN: begin
          if (sb + 2 > rec_end) settle(ST_MALFORMED);
          else skip_then(PH_SID_SKIP, PH_CS_HI, b);
        end
        PH_CS_HI, PH_EXTS_HI, PH_EXT_L0, PH_NAME_L0: begin
          len_hi = b;
          ph     = phase_t'(ph + 1);
        end
        PH_CS_LO: begin
          if (t + 1 > rec_end) settle(ST_MALFORMED);
          else skip_then(PH_CS_SKIP, PH_CM_LEN, ln);
        end
        PH_CM_LEN: begin
          // SSL 3.0 may stop right after the compression methods.
          if (sb == rec_end && ver_major == 8'd3 && ver_minor == 8'd0) settle(ST_NOSNI);
          else if (sb + 2 > rec_end) settle(ST_MALFORMED);
          else skip_then(PH_CM_SKIP, PH_EXTS_HI, b);
        end
        PH_EXTS_LO: begin
          if (t > rec_end) begin
            settle(ST_MALFORMED);
          end else begin
            ext_list_end = 17'(t);
            if (ext_fits(q + 1)) ph = PH_EXT_T0;
          end
        end
        PH_EXT_T0: begin
          type_zero = (b == 8'd0);
          ph        = PH_EXT_T1;
        end
        PH_EXT_T1: begin
          type_zero = type_zero && (b == 8'd0);
          ph        = PH_EXT_L0;
        end
        PH_EXT_L1: begin
          if (type_zero) begin
            if (t > ext_list_end) begin
              settle(ST_MALFORMED);
            end else begin
              ext_end = 17'(t);
              // The two-byte name list length is skipped without a check.
              if (name_fits(q + 3)) skip_then(PH_SNL_SKIP, PH_NAME_TYPE, 2);
            end
          end else if (ext_fits(t)) begin
            skip_then(PH_EXT_SKIP, PH_EXT_T0, ln);
          end
        end
        PH_NAME_TYPE: begin
          type_zero = (b == 8'd0);
          ph        = PH_NAME_L0;
        end
        PH_NAME_L1: begin
          if (t > ext_end) begin
            settle(ST_MALFORMED);
          end else if (type_zero) begin
            found_len = 16'(ln);
            outcome   = ST_FOUND;
            if (ln == 0) begin
              ph = PH_DONE;
            end else begin
              field_left = 16'(ln);
              ph         = PH_NAME_COPY;
            end
          end else if (name_fits(t)) begin
            skip_then(PH_NAME_SKIP, PH_NAME_TYPE, ln);
          end
        end
        PH_NAME_COPY: begin
          item.item_kind   = 1'b0;
          item.host_byte   = b;
          item.status      = ST_FOUND;
          item.name_length = '0;
          item.last        = 1'b0;
          sni_due.push_back(item);
          if (field_left <= 16'd1) ph = PH_DONE;
          else field_left--;
        end
        default: begin
          if (field_left <= 16'd1) ph = after_skip(ph);
          else field_left--;
        end
      endcase
    end

    if (eop) begin
      item.item_kind = 1'b1;
      item.host_byte = '0;
      if (q + 1 < RECORD_HEADER_LEN || q + 1 < rec_end) item.status = ST_INCOMPLETE;
      else item.status = outcome;
      item.name_length = (item.status == ST_FOUND) ? found_len : 16'd0;
      item.last        = 1'b1;
      sni_due.push_back(item);
      clear_parser();
    end else if (pos < POS_MAX) begin
      pos++;
    end
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (rst) begin
      clear_parser();
    end else begin
      // Each accepted request goes through the model before the output side.
      if (s_tvalid && s_tready) parse_hello_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (sni_due.size() == 0) begin
          report_mismatch("result with nothing outstanding", int'(m_tdata), 0);
        end else begin
          want = sni_due.pop_front();
          if (m_tuser !== want.item_kind)
            report_mismatch("item kind", int'(m_tuser), int'(want.item_kind));
          if (m_tdata[7:0] !== want.host_byte)
            report_mismatch("host byte", int'(m_tdata[7:0]), int'(want.host_byte));
          if (m_tdata[9:8] !== want.status)
            report_mismatch("status", int'(m_tdata[9:8]), int'(want.status));
          if (m_tdata[25:10] !== want.name_length)
            report_mismatch("name length", int'(m_tdata[25:10]), int'(want.name_length));
          if (m_tdata[31:26] !== 6'd0)
            report_mismatch("tdata padding", int'(m_tdata[31:26]), 0);
          if (m_tlast !== want.last)
            report_mismatch("last", int'(m_tlast), int'(want.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // ---------------------------------------------------------------- sender

  task automatic offer_byte(logic [7:0] b, logic eop);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eop;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic offer_packet(byte_q_t pkt);
    for (int i = 0; i < pkt.size(); i++) offer_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // ---------------------------------------------------------------- packet builder

  function automatic byte_q_t filler_ext(int len);
    byte_q_t     e;
    logic [15:0] ext_code;
    // Codes with one zero byte must not be taken for server_name.
    case ($urandom_range(3))
      0:       ext_code = 16'h0001;
      1:       ext_code = 16'h0100;
      default: ext_code = 16'($urandom_range(16'h0002, 16'hFFFF));
    endcase
    e.push_back(ext_code[15:8]);
    e.push_back(ext_code[7:0]);
    e.push_back(8'(len >> 8));
    e.push_back(8'(len));
    repeat (len) e.push_back(8'($urandom));
    return e;
  endfunction

  function automatic byte_q_t name_entry_bytes(logic [7:0] name_type, int len, bit binary);
    byte_q_t e;
    e.push_back(name_type);
    e.push_back(8'(len >> 8));
    e.push_back(8'(len));
    for (int i = 0; i < len; i++) begin
      if (!binary) e.push_back(($urandom_range(7) == 0) ? 8'h2E : 8'(8'h61 + $urandom_range(25)));
      else if (i == 0) e.push_back(8'h00);
      else if (i == 1) e.push_back(8'hFF);
      else e.push_back(8'($urandom));
    end
    return e;
  endfunction

  function automatic byte_q_t build_hello(hello_t h);
    byte_q_t exts;
    byte_q_t names;
    byte_q_t tail;
    byte_q_t body;
    byte_q_t pkt;
    if (h.pad_len >= 0) exts = filler_ext(h.pad_len);
    for (int i = 0; i < h.pre_exts; i++) exts = {exts, filler_ext($urandom_range(0, 6))};
    if (h.has_sni) begin
      if (h.other_first)
        names = name_entry_bytes(8'($urandom_range(1, 255)), $urandom_range(0, 5), 1'b1);
      if (h.host_entry)
        names = {names, name_entry_bytes(8'h00, h.name_len, h.name_binary)};
      if (h.trailing_entry)
        names = {names, name_entry_bytes(8'($urandom_range(1, 255)), $urandom_range(0, 4), 1'b1)};
      exts.push_back(8'h00);
      exts.push_back(8'h00);
      exts.push_back(8'((names.size() + 2) >> 8));
      exts.push_back(8'(names.size() + 2));
      exts.push_back(h.snl_field[15:8]);
      exts.push_back(h.snl_field[7:0]);
      exts = {exts, names};
    end
    for (int i = 0; i < h.post_exts; i++) exts = {exts, filler_ext($urandom_range(0, 6))};

    tail.push_back(8'h03);
    tail.push_back(8'h03);
    repeat (32) tail.push_back(8'($urandom));
    tail.push_back(8'(h.sid_len));
    repeat (h.sid_len) tail.push_back(8'($urandom));
    tail.push_back(8'(h.cs_len >> 8));
    tail.push_back(8'(h.cs_len));
    repeat (h.cs_len) tail.push_back(8'($urandom));
    tail.push_back(8'(h.cm_len));
    repeat (h.cm_len) tail.push_back(8'($urandom));
    if (h.has_exts) begin
      tail.push_back(8'(exts.size() >> 8));
      tail.push_back(8'(exts.size()));
      tail = {tail, exts};
    end

    body = '{h.hs_type, 8'h00, 8'(tail.size() >> 8), 8'(tail.size())};
    body = {body, tail};
    pkt  = '{h.content, h.ver_major, h.ver_minor, 8'(body.size() >> 8), 8'(body.size())};
    pkt  = {pkt, body};
    return pkt;
  endfunction

  function automatic hello_t default_hello();
    hello_t h;
    h.content        = HANDSHAKE_CONTENT;
    h.ver_major      = 8'h03;
    h.ver_minor      = 8'h01;
    h.hs_type        = CLIENT_HELLO_TYPE;
    h.sid_len        = 0;
    h.cs_len         = 2;
    h.cm_len         = 1;
    h.has_exts       = 1'b1;
    h.pre_exts       = 0;
    h.post_exts      = 0;
    h.pad_len        = -1;
    h.has_sni        = 1'b1;
    h.other_first    = 1'b0;
    h.host_entry     = 1'b1;
    h.trailing_entry = 1'b0;
    h.name_len       = 11;
    h.name_binary    = 1'b0;
    h.snl_field      = 16'($urandom);
    return h;
  endfunction

  function automatic hello_t random_hello();
    hello_t h;
    h = default_hello();
    case ($urandom_range(9))
      0:       h.ver_major = 8'h02;
      1:       h.ver_major = 8'($urandom_range(4, 255));
      default: h.ver_major = 8'h03;
    endcase
    h.ver_minor = 8'($urandom_range(0, 4));
    h.sid_len   = ($urandom_range(3) == 0) ? 32 : $urandom_range(0, 4);
    h.cs_len    = 2 * $urandom_range(0, 4);
    h.cm_len    = $urandom_range(0, 2);
    h.has_exts  = ($urandom_range(9) != 0);
    if (h.ver_major == 8'h03 && h.ver_minor == 8'h00 && $urandom_range(1) == 1) h.has_exts = 1'b0;
    h.pre_exts       = $urandom_range(0, 2);
    h.post_exts      = $urandom_range(0, 2);
    h.has_sni        = ($urandom_range(9) > 1);
    h.other_first    = ($urandom_range(4) == 0);
    h.host_entry     = ($urandom_range(9) != 0);
    h.trailing_entry = ($urandom_range(4) == 0);
    h.name_len       = ($urandom_range(4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 24);
    h.name_binary    = ($urandom_range(3) == 0);
    return h;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_header_verdicts();
    byte_q_t pkt;
    pkt = '{HANDSHAKE_CONTENT};
    offer_packet(pkt);
    pkt = '{HANDSHAKE_CONTENT, 8'h03, 8'h01, 8'h00};
    offer_packet(pkt);
    // SSLv2-style hello: length bit set and a ClientHello type in the third byte.
    pkt = '{8'h80, 8'h2E, 8'h01, 8'h03, 8'h01, 8'h00, 8'h15};
    offer_packet(pkt);
    pkt = '{8'h80, 8'h10, 8'h02, 8'h00, 8'h00};
    offer_packet(pkt);
    pkt = '{8'h17, 8'h03, 8'h03, 8'h00, 8'h02, 8'h01, 8'h00};
    offer_packet(pkt);
    // An old major version is judged on the header alone, however long the record.
    pkt = '{HANDSHAKE_CONTENT, 8'h02, 8'h00, 8'h00, 8'h30};
    offer_packet(pkt);
    pkt = '{HANDSHAKE_CONTENT, 8'h03, 8'h01, 8'h00, 8'h00};
    offer_packet(pkt);
    pkt = '{HANDSHAKE_CONTENT, 8'h03, 8'h01, 8'h00, 8'h02, CLIENT_HELLO_TYPE, 8'h00};
    offer_packet(pkt);
  endtask

  task automatic test_body_verdicts();
    hello_t  h;
    byte_q_t pkt;
    int      ext_len_at;
    h = default_hello();
    h.hs_type = 8'h02;
    offer_packet(build_hello(h));

    pkt = build_hello(default_hello());
    repeat (10) void'(pkt.pop_back());
    offer_packet(pkt);

    h = default_hello();
    h.ver_minor = 8'h00;
    h.has_exts  = 1'b0;
    offer_packet(build_hello(h));

    h = default_hello();
    ext_len_at = 5 + 4 + 34 + 1 + h.sid_len + 2 + h.cs_len + 1 + h.cm_len;
    pkt = build_hello(h);
    pkt[ext_len_at + 5] = pkt[ext_len_at + 5] + 8'd200;
    offer_packet(pkt);

    h = default_hello();
    h.pre_exts  = 0;
    h.post_exts = 0;
    h.has_sni   = 1'b0;
    offer_packet(build_hello(h));

    // A server_name extension with no room for the name list.
    h = default_hello();
    h.pre_exts = 0;
    pkt = build_hello(h);
    pkt[ext_len_at + 4] = 8'h00;
    pkt[ext_len_at + 5] = 8'h00;
    offer_packet(pkt);

    h = default_hello();
    h.other_first = 1'b1;
    h.host_entry  = 1'b0;
    offer_packet(build_hello(h));
  endtask

  task automatic test_host_names();
    hello_t  h;
    byte_q_t pkt;
    offer_packet(build_hello(default_hello()));

    h = default_hello();
    h.name_len       = 0;
    h.trailing_entry = 1'b1;
    offer_packet(build_hello(h));

    h = default_hello();
    h.name_len  = 0;
    h.post_exts = 0;
    offer_packet(build_hello(h));

    h = default_hello();
    h.name_binary = 1'b1;
    h.name_len    = 9;
    offer_packet(build_hello(h));

    h = default_hello();
    h.other_first = 1'b1;
    h.sid_len     = 32;
    offer_packet(build_hello(h));

    pkt = build_hello(default_hello());
    repeat (6) pkt.push_back(8'($urandom));
    offer_packet(pkt);

    // Packet ends in the middle of the name.
    h = default_hello();
    h.post_exts = 0;
    pkt = build_hello(h);
    repeat (3) void'(pkt.pop_back());
    offer_packet(pkt);
  endtask

  task automatic test_random_traffic(int sidle, int ridle, int budget);
    hello_t  h;
    byte_q_t pkt;
    int      sent;
    int      pick;
    int      len;
    send_idle = sidle;
    recv_idle = ridle;
    sent      = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        len = $urandom_range(1, 12);
        pkt.delete();
        repeat (len) pkt.push_back(8'($urandom));
        case ($urandom_range(3))
          0: pkt[0] = HANDSHAKE_CONTENT;
          1: pkt[0] = 8'h80 | pkt[0];
          default: ;
        endcase
        if (len >= 3 && $urandom_range(1) == 1) pkt[2] = 8'h01;
      end else begin
        h   = random_hello();
        pkt = build_hello(h);
        if (pick < 27) begin
          len = $urandom_range(1, pkt.size() - 1);
          while (pkt.size() > len) void'(pkt.pop_back());
        end else if (pick < 40) begin
          repeat ($urandom_range(1, 2)) pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
        end else if (pick < 48) begin
          repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom));
        end
      end
      offer_packet(pkt);
      sent += pkt.size();
    end
  endtask

  task automatic test_backpressure();
    hello_t h;
    send_idle    = 0;
    recv_idle    = 0;
    hold_request = 300;
    h = default_hello();
    h.name_len = 40;
    offer_packet(build_hello(h));
  endtask

  task automatic test_long_records();
    byte_q_t pkt;
    send_idle = 0;
    recv_idle = 0;
    // A record length field of all ones with only a short body behind it.
    pkt    = build_hello(default_hello());
    pkt[3] = 8'hFF;
    pkt[4] = 8'hFF;
    while (pkt.size() > 12) void'(pkt.pop_back());
    offer_packet(pkt);
  endtask

  initial begin
    int waited;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tlast      = 1'b0;
    m_tready     = 1'b0;
    send_idle    = 21;
    recv_idle    = 73;
    hold_request = 0;
    hold_left    = 0;
    mismatches   = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_header_verdicts();
    test_body_verdicts();
    test_host_names();
    test_random_traffic(21, 73, 60);
    test_random_traffic(73, 21, 60);
    test_random_traffic(0, 0, 60);
    test_backpressure();
    test_long_records();
    s_tvalid <= 1'b0;

    for (waited = 0; sni_due.size() != 0 && waited < 20000; waited++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sni_due.size() != 0) report_mismatch("results never delivered", 0, sni_due.size());

    if (mismatches == 0) begin
      $display("[tls_sni_hostname_extractor_top] OK");
    end else begin
      $display("[tls_sni_hostname_extractor_top] ERROR");
    end
    $finish;
  end

endmodule
